// File: rtl/core/sha256_stream_hasher_top_assert.svh
// Assertion macros for the SHA-256 stream hasher.
`ifndef SHA256_STREAM_HASHER_TOP_ASSERT_SVH
`define SHA256_STREAM_HASHER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SH_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SH_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define SH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/core/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Types, constants and round functions for the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none
package sha_pkg;
  localparam int unsigned LengthPos  = 56;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_PAD, ST_ROUND, ST_FOLD, ST_EMIT
  } sha_state_t;

  // controller -> datapath
  typedef struct packed {
    logic       wr_byte;     // write wr_data into block at fill
    logic [7:0] wr_data;
    logic       count_byte;  // message byte: bump length
    logic       start;       // load working vars from chain
    logic       round;       // one compression round
    logic       fold;        // add working vars into chain
    logic       restart;     // back to initial values
  } sha_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [5:0] fill;
    logic [5:0] round_idx;
    logic [7:0] len_byte;    // length byte at current fill (pad phase)
  } sha_sts_t;

  localparam logic [31:0] K [64] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
    32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
    32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
    32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
    32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
    32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
    32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
    32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
    32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
    32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
    32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

  localparam logic [31:0] H0 [8] = '{
    32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
    32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
    ror = (x >> n) | (x << (32 - n));
  endfunction
endpackage
`default_nettype wire

// File: rtl/core/sha_dp.sv
// ----------------------------------------------------------------------------
// sha_dp
// Block buffer, schedule window, round logic, chaining words and length.
// ----------------------------------------------------------------------------
`default_nettype none
module sha_dp import sha_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  sha_cmd_t         cmd,
  output sha_sts_t         sts,
  output logic [255:0]     digest
);
  logic [31:0] w_r [16];          // 16-word schedule window, also the byte buffer
  logic [31:0] v_r [8];
  logic [31:0] h_r [8];
  logic [5:0]  fill_r, rnd_r;
  logic [63:0] cnt_r;
  logic [63:0] bits;

  assign bits = {cnt_r[60:0], 3'b000};
  assign sts.fill = fill_r;
  assign sts.round_idx = rnd_r;
  // fill 56..63 picks bit-length bytes MSB first
  assign sts.len_byte = bits[{~fill_r[2:0], 3'b000} +: 8];

  logic [31:0] wt, w_new, s0, s1, t1, t2;
  always_comb begin
    wt = w_r[0];
    s0 = ror(w_r[1], 7) ^ ror(w_r[1], 18) ^ (w_r[1] >> 3);
    s1 = ror(w_r[14], 17) ^ ror(w_r[14], 19) ^ (w_r[14] >> 10);
    w_new = w_r[0] + s0 + w_r[9] + s1;
    t1 = v_r[7] + (ror(v_r[4], 6) ^ ror(v_r[4], 11) ^ ror(v_r[4], 25))
       + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6])) + K[rnd_r] + wt;
    t2 = (ror(v_r[0], 2) ^ ror(v_r[0], 13) ^ ror(v_r[0], 22))
       + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_byte) begin
      // bytes enter at the tail; after 64 of them word 0 holds bytes 0..3
      for (int i = 0; i < 15; i++) w_r[i] <= {w_r[i][23:0], w_r[i+1][31:24]};
      w_r[15] <= {w_r[15][23:0], cmd.wr_data};
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= w_new;
    end
    if (cmd.start) begin
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    end else if (cmd.round) begin
      v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.restart) begin
      for (int i = 0; i < 8; i++) h_r[i] <= H0[i];
      fill_r <= '0;
      cnt_r  <= '0;
      rnd_r  <= '0;
    end else begin
      if (cmd.wr_byte) fill_r <= fill_r + 6'd1;
      if (cmd.count_byte) cnt_r <= cnt_r + 64'd1;
      if (cmd.start) rnd_r <= '0;
      else if (cmd.round) rnd_r <= rnd_r + 6'd1;
      if (cmd.fold)
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
    end
  end

  always_comb
    for (int i = 0; i < 8; i++) digest[32*i +: 32] = h_r[i];
endmodule
`default_nettype wire

// File: rtl/core/sha_ctrl.sv
// ----------------------------------------------------------------------------
// sha_ctrl
// Sequencer: byte intake, padding, 64 rounds per block, digest handoff.
// ----------------------------------------------------------------------------
`default_nettype none
module sha_ctrl import sha_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic  in_present,
  input  wire logic  in_last,
  output logic       out_valid,
  input  wire logic  out_ready,
  input  sha_sts_t   sts,
  output sha_cmd_t   cmd
);
  sha_state_t state_r, state_nxt;
  logic pad_r, pad_nxt;          // finishing a message
  logic mark_r, mark_nxt;        // 0x80 already written
  logic last_r, last_nxt;        // end mark pending after current block
  logic len_r, len_nxt;          // block being padded carries the length
  logic acc;

  assign acc = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; pad_r <= 1'b0; mark_r <= 1'b0; last_r <= 1'b0;
    end else begin
      state_r <= state_nxt; pad_r <= pad_nxt; mark_r <= mark_nxt; last_r <= last_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pad_nxt = pad_r; mark_nxt = mark_r; last_nxt = last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (in_present && sts.fill == 6'd63) begin
            state_nxt = ST_LOAD; last_nxt = in_last;
          end else if (in_last) begin
            state_nxt = ST_PAD; pad_nxt = 1'b1; mark_nxt = 1'b0;
          end
        end
      end
      ST_PAD: begin
        if (!mark_r) mark_nxt = 1'b1;
        if (sts.fill == 6'd63) state_nxt = ST_LOAD;
      end
      ST_LOAD:  state_nxt = ST_ROUND;
      ST_ROUND: if (sts.round_idx == 6'd63) state_nxt = ST_FOLD;
      ST_FOLD: begin
        if (last_r) begin
          state_nxt = ST_PAD; pad_nxt = 1'b1; mark_nxt = 1'b0; last_nxt = 1'b0;
        end else if (pad_r) begin
          // done once the block with the length has been folded in
          if (mark_r && len_r) state_nxt = ST_EMIT;
          else state_nxt = ST_PAD;
        end else state_nxt = ST_IDLE;
      end
      ST_EMIT: if (out_ready) begin
        state_nxt = ST_IDLE; pad_nxt = 1'b0; mark_nxt = 1'b0;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) len_r <= 1'b0;
    else len_r <= len_nxt;
  end

  always_comb begin
    cmd = '0;
    len_nxt = len_r;
    in_ready = (state_r == ST_IDLE);
    out_valid = (state_r == ST_EMIT);
    unique case (state_r)
      ST_IDLE: begin
        len_nxt = 1'b0;
        if (acc && in_present) begin
          cmd.wr_byte = 1'b1; cmd.wr_data = in_byte; cmd.count_byte = 1'b1;
        end
      end
      ST_PAD: begin
        cmd.wr_byte = 1'b1;
        if (!mark_r) begin
          cmd.wr_data = 8'h80;
          // length can go in this block only if mark lands below 56
          len_nxt = (sts.fill < 6'(LengthPos));
        end else if (len_r) cmd.wr_data = (sts.fill >= 6'(LengthPos)) ? sts.len_byte : 8'h00;
        else cmd.wr_data = 8'h00;
      end
      ST_LOAD:  cmd.start = 1'b1;
      ST_ROUND: cmd.round = 1'b1;
      ST_FOLD: begin
        cmd.fold = 1'b1;
        // zero-only pad block done: the next one carries the length
        if (pad_r && !len_r) len_nxt = 1'b1;
      end
      ST_EMIT:  if (out_ready) cmd.restart = 1'b1;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// File: rtl/core/sha256_stream_hasher_top.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher_top
// SHA-256 over a byte stream, one byte per item, digest on end mark.
// ----------------------------------------------------------------------------
// in_tdata[7:0] carries a byte when in_tuser is 1; in_tlast ends the message.
// An item with no byte and no end mark is accepted and ignored.
// Byte intake accepts one item per cycle while not stalled. Each 64th byte stalls input
// for one load, 64 rounds of a single shared round unit and one fold.
// After an end mark the controller pads byte by byte, runs one or two
// more compressions, then presents the digest on out_tdata
// (word 0 in the low 32 bits) with out_tvalid held until out_tready.
// Input stays stalled while the digest waits; taking it restores the
// initial chaining values for the next message.
// Reset (rst_n low, synchronous) restores initial values and empties the
// block; the block buffer itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sha256_stream_hasher_top_assert.svh"
module sha256_stream_hasher_top import sha_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // data_byte
  input  wire logic         in_tuser,   // byte_present
  input  wire logic         in_tlast,   // last_of_message
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [255:0]      out_tdata   // digest_word_0 .. digest_word_7
);
  sha_cmd_t   cmd;
  sha_sts_t   sts;

  sha_ctrl u_ctrl (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .in_byte(in_tdata),
    .in_present(in_tuser), .in_last(in_tlast), .out_valid(out_tvalid),
    .out_ready(out_tready), .sts, .cmd);

  sha_dp u_dp (.clk, .rst_n, .cmd, .sts, .digest(out_tdata));

  `SH_ASSERT_IMPL(a_excl, clk, rst_n, out_tvalid, !in_tready)
  `SH_ASSERT_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata))
  `SH_ASSERT_IMPL(a_busy, clk, rst_n, cmd.round, !in_tready && !out_tvalid)
endmodule
`default_nettype wire

// File: sim/tb_sha256_stream_hasher_top.sv
// ----------------------------------------------------------------------------
// tb_sha256_stream_hasher_top
// Self-checking bench: random messages hashed by a local SHA-256 model,
// digests checked word by word, with bursty input and stalling output.
// ----------------------------------------------------------------------------
`default_nettype none

class digest_scoreboard;
  localparam logic [31:0] RC [64] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
    32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
    32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
    32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
    32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
    32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
    32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
    32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
    32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
    32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
    32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
  localparam logic [31:0] IV [8] = '{
    32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
    32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};

  logic [31:0]  chain [8];
  logic [7:0]   blk [64];
  int unsigned  fill;
  logic [63:0]  msg_len;
  logic [255:0] pending_digests [$];
  int unsigned  errors;

  function new();
    errors = 0;
    restart();
  endfunction

  function void restart();
    for (int i = 0; i < 8; i++) chain[i] = IV[i];
    fill = 0;
    msg_len = '0;
  endfunction

  function logic [31:0] rr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function void compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int t = 0; t < 16; t++)
      w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
    for (int t = 16; t < 64; t++)
      w[t] = w[t-16] + (rr(w[t-15], 7) ^ rr(w[t-15], 18) ^ (w[t-15] >> 3))
           + w[t-7] + (rr(w[t-2], 17) ^ rr(w[t-2], 19) ^ (w[t-2] >> 10));
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RC[t] + w[t];
      t2 = (rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] += v[i];
  endfunction

  function void push_byte(logic [7:0] b);
    blk[fill] = b;
    fill++;
    if (fill == 64) begin
      compress();
      fill = 0;
    end
  endfunction

  function void note_item(logic [7:0] data, logic present, logic last);
    logic [63:0]  bits;
    logic [255:0] dg;
    if (present) begin
      push_byte(data);
      msg_len++;
    end
    if (!last) return;
    bits = msg_len << 3;
    push_byte(8'h80);
    while (fill != 56) push_byte(8'h00);
    for (int i = 0; i < 8; i++) push_byte(bits[63 - 8*i -: 8]);
    for (int k = 0; k < 8; k++) dg[32*k +: 32] = chain[k];
    pending_digests = {pending_digests, dg};
    restart();
  endfunction

  function void check_digest(logic [255:0] got);
    logic [255:0] exp;
    if (pending_digests.size() == 0) begin
      $error("unexpected digest %h", got);
      errors++;
      return;
    end
    exp = pending_digests.pop_front();
    for (int k = 0; k < 8; k++)
      if (got[32*k +: 32] !== exp[32*k +: 32]) begin
        $error("digest_word_%0d: expected %h, got %h", k, exp[32*k +: 32], got[32*k +: 32]);
        errors++;
      end
  endfunction
endclass

module tb_sha256_stream_hasher_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdleLimit = 20000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [255:0] out_tdata;

  digest_scoreboard sb = new();
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  bit          stall_mode = 1'b0;

  sha256_stream_hasher_top dut (.*);

  always #5 clk = ~clk;

  // sample at the rising edge; both handshakes here
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_item(in_tdata, in_tuser, in_tlast);
      if (out_tvalid && out_tready) sb.check_digest(out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // receiver: alternating phases of full speed and random stalls
  always @(negedge clk) begin
    if ($urandom_range(0, 99) == 0) stall_mode <= ~stall_mode;
    out_tready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
  end

  // drive one item; gaps only between bursts, valid stays up inside a burst
  task automatic send_item(input logic [7:0] d, input logic p, input logic l);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= p;
    in_tlast  <= l;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_message(input int unsigned len);
    for (int i = 0; i < len; i++) begin
      // occasional empty items inside the message
      if ($urandom_range(0, 15) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, (i == len - 1));
    end
    if (len == 0) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (sb.pending_digests.size() != 0) @(negedge clk);
  endtask

  initial begin
    int unsigned n;
    int unsigned lens [$];
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty message, extreme bytes, byte with end mark, idle item
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b0);
    send_item(8'h5a, 1'b0, 1'b1);
    send_item(8'haa, 1'b1, 1'b0);
    send_item(8'h55, 1'b1, 1'b1);
    wait_drained();

    // pad boundaries: 55/56 bytes and one block minus one / exact
    lens = '{55, 56, 63, 64};
    foreach (lens[i]) send_message(lens[i]);

    n = 0;
    while (n < 350) begin
      int unsigned len;
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 130) : $urandom_range(0, 20);
      send_message(len);
      n += len + 1;
      if ($urandom_range(0, 9) == 0) wait_drained();
    end

    wait_drained();
    repeat (400) @(negedge clk);
    if (sb.errors == 0 && sb.pending_digests.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

`default_nettype wire
